// File: rtl/aar_pkg.sv
// Package with payload types, pipeline types and constants for axis-angle to rotation.
`timescale 1ns / 1ps
package aar_pkg;

    // Field formats: every field is 16 bits, axis and result Q2.14, angle Q3.13.
    localparam int DataWidth   = 16;
    localparam int FracBits    = DataWidth - 2;
    localparam int AngleShift  = 25 - FracBits;
    localparam int CordicIters = 20;
    localparam int OutShift    = 30 - FracBits;

    localparam int ZW  = 28;
    localparam int XYW = 34;
    localparam int SW  = 18;
    localparam int PW  = 2 * DataWidth;
    localparam int W2W = 20;
    localparam int SMW = SW + DataWidth;
    localparam int OMW = SW + W2W;
    localparam int AW  = 40;

    localparam logic signed [DataWidth-1:0] AxisOne  = DataWidth'(1 << FracBits);
    localparam logic signed [DataWidth-1:0] AxisMone = -AxisOne;
    localparam logic signed [ZW-1:0]  HalfPiQ24 = ZW'(26353589);
    localparam logic signed [ZW-1:0]  PiQ24     = ZW'(52707179);
    localparam logic signed [XYW-1:0] CordicK   = XYW'(652032874);
    localparam logic signed [SW-1:0]  OneQF     = SW'(1 << FracBits);

    // Arctangent of 2^-i in Q.24.
    localparam logic signed [ZW-1:0] AtanQ24 [CordicIters] = '{
        ZW'(13176795), ZW'(7778716), ZW'(4110060), ZW'(2086331), ZW'(1047214),
        ZW'(524117), ZW'(262123), ZW'(131069), ZW'(65536), ZW'(32768),
        ZW'(16384), ZW'(8192), ZW'(4096), ZW'(2048), ZW'(1024),
        ZW'(512), ZW'(256), ZW'(128), ZW'(64), ZW'(32)
    };

    typedef struct packed {
        logic signed [DataWidth-1:0] axis_x;
        logic signed [DataWidth-1:0] axis_y;
        logic signed [DataWidth-1:0] axis_z;
        logic signed [DataWidth-1:0] angle;
    } t_aar_in;

    typedef struct packed {
        logic signed [DataWidth-1:0] rot_r0c0;
        logic signed [DataWidth-1:0] rot_r0c1;
        logic signed [DataWidth-1:0] rot_r0c2;
        logic signed [DataWidth-1:0] rot_r1c0;
        logic signed [DataWidth-1:0] rot_r1c1;
        logic signed [DataWidth-1:0] rot_r1c2;
        logic signed [DataWidth-1:0] rot_r2c0;
        logic signed [DataWidth-1:0] rot_r2c1;
        logic signed [DataWidth-1:0] rot_r2c2;
    } t_aar_out;

    // Working state of one item as it moves down the pipeline.
    typedef struct packed {
        logic signed [DataWidth-1:0] ax;
        logic signed [DataWidth-1:0] ay;
        logic signed [DataWidth-1:0] az;
        logic signed [ZW-1:0]  z;
        logic                  flip;
        logic signed [XYW-1:0] x;
        logic signed [XYW-1:0] y;
        logic signed [PW-1:0]  p_xx;
        logic signed [PW-1:0]  p_yy;
        logic signed [PW-1:0]  p_zz;
        logic signed [PW-1:0]  p_xy;
        logic signed [PW-1:0]  p_xz;
        logic signed [PW-1:0]  p_yz;
        logic signed [W2W-1:0] w2_d0;
        logic signed [W2W-1:0] w2_d1;
        logic signed [W2W-1:0] w2_d2;
        logic signed [W2W-1:0] w2_xy;
        logic signed [W2W-1:0] w2_xz;
        logic signed [W2W-1:0] w2_yz;
        logic signed [SW-1:0]  s;
        logic signed [SW-1:0]  omc;
        logic signed [SMW-1:0] sw_x;
        logic signed [SMW-1:0] sw_y;
        logic signed [SMW-1:0] sw_z;
        logic signed [OMW-1:0] om_d0;
        logic signed [OMW-1:0] om_d1;
        logic signed [OMW-1:0] om_d2;
        logic signed [OMW-1:0] om_xy;
        logic signed [OMW-1:0] om_xz;
        logic signed [OMW-1:0] om_yz;
    } t_aar_pipe;

endpackage

// File: rtl/aar_cordic_stage.sv
// One rotation-mode CORDIC iteration with a fixed shift.
`timescale 1ns / 1ps
module aar_cordic_stage #(
    parameter int ITER = 0
) (
    input  aar_pkg::t_aar_pipe i_pipe,
    output aar_pkg::t_aar_pipe o_pipe
);
    import aar_pkg::*;

    logic signed [XYW-1:0] dx;
    logic signed [XYW-1:0] dy;

    // Rotate toward zero residual angle; shifts floor toward minus infinity.
    always_comb begin
        dx = i_pipe.y >>> ITER;
        dy = i_pipe.x >>> ITER;
        o_pipe = i_pipe;
        if (i_pipe.z >= 0) begin
            o_pipe.x = i_pipe.x - dx;
            o_pipe.y = i_pipe.y + dy;
            o_pipe.z = i_pipe.z - AtanQ24[ITER];
        end else begin
            o_pipe.x = i_pipe.x + dx;
            o_pipe.y = i_pipe.y - dy;
            o_pipe.z = i_pipe.z + AtanQ24[ITER];
        end
    end

endmodule

// File: rtl/axis_angle_to_rotation.sv
// Top level: pipelined Rodrigues rotation from an axis and an angle.
//
//   channel | direction | handshake             | payload
//   input   | in        | i_valid / o_stall     | i_data (axis x, y, z, angle)
//   output  | out       | o_valid / i_stall     | o_data (nine matrix entries)
//
// One item enters per cycle while o_stall is low. The depth is set by the
// 20 CORDIC iterations, one per stage, plus input, fold, rounding, multiply
// and final sum stages. Reset clears only the stage valid bits. A stalled
// output holds; each stage keeps loading while the stage after it is empty
// or moving, so bubbles close up.
`timescale 1ns / 1ps
module axis_angle_to_rotation (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  aar_pkg::t_aar_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output aar_pkg::t_aar_out o_data
);
    import aar_pkg::*;

    localparam int CordicFirst = 1;
    localparam int CordicLast  = CordicFirst + CordicIters;
    localparam int RoundStage  = CordicLast + 1;
    localparam int MultStage   = RoundStage + 1;
    localparam int OutStage    = MultStage + 1;

    logic [OutStage:0] r_v;
    logic [OutStage:0] en;
    t_aar_in   r_in;
    t_aar_pipe r_pipe [CordicFirst:MultStage];
    t_aar_pipe n_pipe [CordicFirst:MultStage];
    t_aar_out  r_out;
    t_aar_out  n_out;

    // Stage enables: a stage loads when it is empty or its successor moves.
    assign en[OutStage] = !r_v[OutStage] || !i_stall;
    genvar g;
    generate
        for (g = 0; g < OutStage; g++) begin : g_en
            assign en[g] = !r_v[g] || en[g+1];
        end
    endgenerate

    assign o_stall = !en[0];
    assign o_valid = r_v[OutStage];
    assign o_data  = r_out;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= OutStage; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_in <= i_data;
        end
    end

    // Axis clamp, angle to Q.24 and quadrant fold.
    logic signed [ZW-1:0] zin;
    always_comb begin
        n_pipe[CordicFirst] = '0;
        zin = ZW'(r_in.angle) <<< AngleShift;
        n_pipe[CordicFirst].ax = (r_in.axis_x > AxisOne) ? AxisOne :
                                 (r_in.axis_x < AxisMone) ? AxisMone : r_in.axis_x;
        n_pipe[CordicFirst].ay = (r_in.axis_y > AxisOne) ? AxisOne :
                                 (r_in.axis_y < AxisMone) ? AxisMone : r_in.axis_y;
        n_pipe[CordicFirst].az = (r_in.axis_z > AxisOne) ? AxisOne :
                                 (r_in.axis_z < AxisMone) ? AxisMone : r_in.axis_z;
        n_pipe[CordicFirst].x = CordicK;
        n_pipe[CordicFirst].y = '0;
        if (zin > HalfPiQ24) begin
            n_pipe[CordicFirst].z    = zin - PiQ24;
            n_pipe[CordicFirst].flip = 1'b1;
        end else if (zin < -HalfPiQ24) begin
            n_pipe[CordicFirst].z    = zin + PiQ24;
            n_pipe[CordicFirst].flip = 1'b1;
        end else begin
            n_pipe[CordicFirst].z    = zin;
            n_pipe[CordicFirst].flip = 1'b0;
        end
    end

    // CORDIC stages; the axis products and squared-skew terms ride along.
    generate
        for (g = 0; g < CordicIters; g++) begin : g_cordic
            t_aar_pipe c_out;
            logic signed [PW+1:0] t_d0, t_d1, t_d2, t_xy, t_xz, t_yz;

            aar_cordic_stage #(.ITER(g)) u_stage (
                .i_pipe (r_pipe[CordicFirst+g]),
                .o_pipe (c_out)
            );

            always_comb begin
                n_pipe[CordicFirst+g+1] = c_out;
                t_d0 = '0;
                t_d1 = '0;
                t_d2 = '0;
                t_xy = '0;
                t_xz = '0;
                t_yz = '0;
                if (g == 0) begin
                    n_pipe[CordicFirst+g+1].p_xx = c_out.ax * c_out.ax;
                    n_pipe[CordicFirst+g+1].p_yy = c_out.ay * c_out.ay;
                    n_pipe[CordicFirst+g+1].p_zz = c_out.az * c_out.az;
                    n_pipe[CordicFirst+g+1].p_xy = c_out.ax * c_out.ay;
                    n_pipe[CordicFirst+g+1].p_xz = c_out.ax * c_out.az;
                    n_pipe[CordicFirst+g+1].p_yz = c_out.ay * c_out.az;
                end
                if (g == 1) begin
                    // Round the squared-skew entries from Q.28 to Q.14.
                    t_d0 = -((PW+2)'(c_out.p_yy) + (PW+2)'(c_out.p_zz))
                           + (PW+2)'(1 << (FracBits-1));
                    t_d1 = -((PW+2)'(c_out.p_xx) + (PW+2)'(c_out.p_zz))
                           + (PW+2)'(1 << (FracBits-1));
                    t_d2 = -((PW+2)'(c_out.p_xx) + (PW+2)'(c_out.p_yy))
                           + (PW+2)'(1 << (FracBits-1));
                    t_xy = (PW+2)'(c_out.p_xy) + (PW+2)'(1 << (FracBits-1));
                    t_xz = (PW+2)'(c_out.p_xz) + (PW+2)'(1 << (FracBits-1));
                    t_yz = (PW+2)'(c_out.p_yz) + (PW+2)'(1 << (FracBits-1));
                    n_pipe[CordicFirst+g+1].w2_d0 = W2W'(t_d0 >>> FracBits);
                    n_pipe[CordicFirst+g+1].w2_d1 = W2W'(t_d1 >>> FracBits);
                    n_pipe[CordicFirst+g+1].w2_d2 = W2W'(t_d2 >>> FracBits);
                    n_pipe[CordicFirst+g+1].w2_xy = W2W'(t_xy >>> FracBits);
                    n_pipe[CordicFirst+g+1].w2_xz = W2W'(t_xz >>> FracBits);
                    n_pipe[CordicFirst+g+1].w2_yz = W2W'(t_yz >>> FracBits);
                end
            end
        end
    endgenerate

    // Undo the fold, round sine and cosine to Q.14 and form one minus cosine.
    logic signed [XYW:0] xf, yf, sr, cr;
    logic signed [SW-1:0] c_q;
    always_comb begin
        n_pipe[RoundStage] = r_pipe[CordicLast];
        xf = r_pipe[CordicLast].flip ? -(XYW+1)'(r_pipe[CordicLast].x)
                                     : (XYW+1)'(r_pipe[CordicLast].x);
        yf = r_pipe[CordicLast].flip ? -(XYW+1)'(r_pipe[CordicLast].y)
                                     : (XYW+1)'(r_pipe[CordicLast].y);
        sr = (yf + (XYW+1)'(1 << (OutShift-1))) >>> OutShift;
        cr = (xf + (XYW+1)'(1 << (OutShift-1))) >>> OutShift;
        c_q = SW'(cr);
        n_pipe[RoundStage].s   = SW'(sr);
        n_pipe[RoundStage].omc = OneQF - c_q;
    end

    // Products of sine with the skew terms and of one minus cosine with W squared.
    always_comb begin
        n_pipe[MultStage] = r_pipe[RoundStage];
        n_pipe[MultStage].sw_x  = r_pipe[RoundStage].s * r_pipe[RoundStage].ax;
        n_pipe[MultStage].sw_y  = r_pipe[RoundStage].s * r_pipe[RoundStage].ay;
        n_pipe[MultStage].sw_z  = r_pipe[RoundStage].s * r_pipe[RoundStage].az;
        n_pipe[MultStage].om_d0 = r_pipe[RoundStage].omc * r_pipe[RoundStage].w2_d0;
        n_pipe[MultStage].om_d1 = r_pipe[RoundStage].omc * r_pipe[RoundStage].w2_d1;
        n_pipe[MultStage].om_d2 = r_pipe[RoundStage].omc * r_pipe[RoundStage].w2_d2;
        n_pipe[MultStage].om_xy = r_pipe[RoundStage].omc * r_pipe[RoundStage].w2_xy;
        n_pipe[MultStage].om_xz = r_pipe[RoundStage].omc * r_pipe[RoundStage].w2_xz;
        n_pipe[MultStage].om_yz = r_pipe[RoundStage].omc * r_pipe[RoundStage].w2_yz;
    end

    // Pipeline data registers.
    always_ff @(posedge i_clk) begin
        for (int k = CordicFirst; k <= MultStage; k++) begin
            if (en[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    // Final sums, rounding and saturation.
    function automatic logic signed [DataWidth-1:0] sat_round(
        input logic signed [AW-1:0] acc
    );
        logic signed [AW-1:0] r;
        r = (acc + AW'(1 << (FracBits-1))) >>> FracBits;
        if (r > AW'((1 << (DataWidth-1)) - 1)) begin
            return DataWidth'((1 << (DataWidth-1)) - 1);
        end else if (r < -AW'(1 << (DataWidth-1))) begin
            return DataWidth'(-(1 << (DataWidth-1)));
        end
        return DataWidth'(r);
    endfunction

    t_aar_pipe m;
    logic signed [AW-1:0] one2f;
    always_comb begin
        m = r_pipe[MultStage];
        one2f = AW'(1) <<< (2 * FracBits);
        n_out.rot_r0c0 = sat_round(one2f + AW'(m.om_d0));
        n_out.rot_r0c1 = sat_round(-AW'(m.sw_z) + AW'(m.om_xy));
        n_out.rot_r0c2 = sat_round(AW'(m.sw_y) + AW'(m.om_xz));
        n_out.rot_r1c0 = sat_round(AW'(m.sw_z) + AW'(m.om_xy));
        n_out.rot_r1c1 = sat_round(one2f + AW'(m.om_d1));
        n_out.rot_r1c2 = sat_round(-AW'(m.sw_x) + AW'(m.om_yz));
        n_out.rot_r2c0 = sat_round(-AW'(m.sw_y) + AW'(m.om_xz));
        n_out.rot_r2c1 = sat_round(AW'(m.sw_x) + AW'(m.om_yz));
        n_out.rot_r2c2 = sat_round(one2f + AW'(m.om_d2));
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (en[OutStage]) begin
            r_out <= n_out;
        end
    end

endmodule

// File: rtl/aar_checker.sv
// Port-level checker for the rotation pipeline and its bind.
`timescale 1ns / 1ps
module aar_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input aar_pkg::t_aar_in  i_data,
    input logic              o_valid,
    input logic              i_stall,
    input aar_pkg::t_aar_out o_data
);
    // A held result keeps its value until the transfer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // A stalled input transfer keeps its payload until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data))
        else $error("stalled input changed");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Input backpressure only when the pipeline is full and the output stalls.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with room in the pipeline");

endmodule

bind axis_angle_to_rotation aar_checker u_aar_checker (.*);

// File: tb/sv/axis_angle_to_rotation_tb.sv
// Testbench for the axis-angle to rotation pipeline: directed and random transfers.
`timescale 1ns / 1ps
module axis_angle_to_rotation_tb;
    import aar_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 40;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_aar_in  in_data;
    logic     out_valid;
    logic     out_stall;
    t_aar_out out_data;

    t_aar_out matrix_queue[$];
    int       mismatch_count;
    int       cycle_count;
    bit       stall_hold;

    axis_angle_to_rotation u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_data)
    );

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Floor shift and round-half-up shift on wide signed values.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        if (s == 0) begin
            return v;
        end
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Predicts the rotation matrix for one input transfer.
    function automatic t_aar_out rodrigues_matrix(t_aar_in item);
        longint one, ax, ay, az, z, x, y, dx, dy, s, c, omc, acc, r;
        longint w[9];
        longint w2[9];
        longint atan_tab[20];
        bit     flip;
        logic signed [DataWidth-1:0] res[9];
        t_aar_out o;
        atan_tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                     131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                     128, 64, 32};
        one = longint'(1) << FracBits;
        ax = clip(longint'(item.axis_x), -one, one);
        ay = clip(longint'(item.axis_y), -one, one);
        az = clip(longint'(item.axis_z), -one, one);
        z = longint'(item.angle) <<< (25 - FracBits);
        flip = 1'b0;
        // Fold the angle into the CORDIC convergence range.
        if (z > 26353589) begin
            z -= 52707179;
            flip = 1'b1;
        end else if (z < -26353589) begin
            z += 52707179;
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        for (int i = 0; i < 20; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = round_shift(y, 30 - FracBits);
        c = round_shift(x, 30 - FracBits);
        omc = one - c;
        w = '{0, -az, ay, az, 0, -ax, -ay, ax, 0};
        w2 = '{-(ay * ay + az * az), ax * ay, ax * az,
               ax * ay, -(ax * ax + az * az), ay * az,
               ax * az, ay * az, -(ax * ax + ay * ay)};
        for (int i = 0; i < 9; i++) begin
            acc = s * w[i] + omc * round_shift(w2[i], FracBits);
            if (i == 0 || i == 4 || i == 8) begin
                acc += longint'(1) << (2 * FracBits);
            end
            r = clip(round_shift(acc, FracBits), -(longint'(1) << (DataWidth - 1)),
                     (longint'(1) << (DataWidth - 1)) - 1);
            res[i] = r[DataWidth-1:0];
        end
        o = '{res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8]};
        return o;
    endfunction

    // Sends one item and records its expected matrix on transfer.
    task automatic send_item(t_aar_in item);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        matrix_queue.push_back(rodrigues_matrix(item));
    endtask

    task automatic send_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            in_data  <= t_aar_in'({$urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic t_aar_in make_item(int ax, int ay, int az, int ang);
        t_aar_in item;
        item.axis_x = DataWidth'(ax);
        item.axis_y = DataWidth'(ay);
        item.axis_z = DataWidth'(az);
        item.angle  = DataWidth'(ang);
        return item;
    endfunction

    // Unit axes, field extremes, angle fold limits and unnormalized axes.
    task automatic test_directed();
        int angles[6];
        angles = '{0, 12868, -12868, 25736, -25736, 32767};
        foreach (angles[k]) begin
            send_item(make_item(16384, 0, 0, angles[k]));
            send_item(make_item(0, -16384, 0, angles[k]));
            send_item(make_item(0, 0, 16384, angles[k]));
        end
        send_item(make_item(32767, -32768, 32767, -32768));
        send_item(make_item(-32768, 32767, -32768, 12869));
        send_item(make_item(16384, 16384, 16384, 25736));
        send_item(make_item(0, 0, 0, 5000));
        send_item(make_item(9459, 9459, 9459, -20000));
    endtask

    // Random transfers: mostly unit-like axes within range, some raw noise.
    task automatic test_random(int count);
        t_aar_in item;
        real     vx, vy, vz, n;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                item = t_aar_in'({$urandom, $urandom});
            end else begin
                vx = real'($urandom_range(0, 2000)) - 1000.0;
                vy = real'($urandom_range(0, 2000)) - 1000.0;
                vz = real'($urandom_range(0, 2000)) - 1000.0;
                n  = $sqrt(vx * vx + vy * vy + vz * vz) + 1.0e-9;
                item = make_item(int'(vx / n * 16384.0), int'(vy / n * 16384.0),
                                 int'(vz / n * 16384.0),
                                 int'($urandom_range(0, 51472)) - 25736);
            end
            send_item(item);
            send_gap();
        end
        in_valid <= 1'b0;
    endtask

    // Output stall pattern: stretches of free flow and stretches of random stalls.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) begin
                stall_hold <= ~stall_hold;
            end
            out_stall <= stall_hold ? ($urandom_range(0, 2) == 0) : 1'b0;
        end
    end

    // Result checker against the oldest expected matrix.
    always @(posedge clk) begin
        t_aar_out exp_m;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall) begin
            if (matrix_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result transfer %h", out_data);
                end
            end else begin
                exp_m = matrix_queue.pop_front();
                if (exp_m !== out_data) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("matrix differs: expected %h actual %h", exp_m, out_data);
                    end
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge clk) begin
        if (cycle_count > CycleLimit) begin
            $display("axis_angle_to_rotation: mismatch");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(750);
        while (matrix_queue.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (mismatch_count == 0 && matrix_queue.size() == 0) begin
            $display("axis_angle_to_rotation: match");
        end else begin
            $display("axis_angle_to_rotation: mismatch");
        end
        $finish;
    end
endmodule

// File: axis_angle_to_rotation.f
rtl/aar_pkg.sv
rtl/aar_cordic_stage.sv
rtl/axis_angle_to_rotation.sv
rtl/aar_checker.sv
tb/sv/axis_angle_to_rotation_tb.sv
